/* design/thmc_pkg.sv */
// shared constants, types and segment tables for the heat colormap
`default_nettype none
package thmc_pkg;

    localparam int TEMP_W    = 16;
    localparam int GLOW_W    = 8;
    localparam int CH_W      = 8;
    localparam int N_CH      = 4;
    localparam int D_W       = 11;
    localparam int NUM_W     = 19;
    localparam int RCP_SHIFT = 24;
    localparam int RCP_W     = 20;
    localparam int PROD_W    = NUM_W + RCP_W;
    localparam int SEG_W     = 3;
    localparam int ALPHA_P_W = CH_W + GLOW_W;
    localparam int P_EXT_W   = 2 * ALPHA_P_W;

    // channel order inside an rgba word
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int CH_A = 3;

    localparam logic [SEG_W-1:0] SEG_COLD   = 3'd0;
    localparam logic [SEG_W-1:0] SEG_ICE    = 3'd1;
    localparam logic [SEG_W-1:0] SEG_WHITE  = 3'd2;
    localparam logic [SEG_W-1:0] SEG_ORANGE = 3'd3;
    localparam logic [SEG_W-1:0] SEG_RED    = 3'd4;
    localparam logic [SEG_W-1:0] SEG_YELLOW = 3'd5;

    localparam logic [TEMP_W-1:0] T_ICE    = 16'd273;
    localparam logic [TEMP_W-1:0] T_WHITE  = 16'd293;
    localparam logic [TEMP_W-1:0] T_ORANGE = 16'd323;
    localparam logic [TEMP_W-1:0] T_RED    = 16'd800;
    localparam logic [TEMP_W-1:0] T_YELLOW = 16'd1500;
    localparam logic [TEMP_W-1:0] T_SAT    = 16'd3000;

    localparam int SPAN_COLD   = 273;
    localparam int SPAN_ICE    = 20;
    localparam int SPAN_WHITE  = 30;
    localparam int SPAN_ORANGE = 477;
    localparam int SPAN_RED    = 700;
    localparam int SPAN_YELLOW = 1500;

    localparam int RCP_COLD   = (1 << RCP_SHIFT) / SPAN_COLD;
    localparam int RCP_ICE    = (1 << RCP_SHIFT) / SPAN_ICE;
    localparam int RCP_WHITE  = (1 << RCP_SHIFT) / SPAN_WHITE;
    localparam int RCP_ORANGE = (1 << RCP_SHIFT) / SPAN_ORANGE;
    localparam int RCP_RED    = (1 << RCP_SHIFT) / SPAN_RED;
    localparam int RCP_YELLOW = (1 << RCP_SHIFT) / SPAN_YELLOW;

    typedef logic [N_CH-1:0][CH_W-1:0]  t_rgba;
    typedef logic [N_CH-1:0][NUM_W-1:0] t_num;

    function automatic t_rgba mk_rgba(input int r, input int g, input int b, input int a);
        t_rgba res;
        res[CH_R] = CH_W'(r);
        res[CH_G] = CH_W'(g);
        res[CH_B] = CH_W'(b);
        res[CH_A] = CH_W'(a);
        return res;
    endfunction

    function automatic t_rgba seg_start(input logic [SEG_W-1:0] seg);
        t_rgba res;
        case (seg)
            SEG_COLD:   res = mk_rgba(0, 50, 150, 150);
            SEG_ICE:    res = mk_rgba(0, 121, 241, 100);
            SEG_WHITE:  res = mk_rgba(255, 255, 255, 0);
            SEG_ORANGE: res = mk_rgba(255, 100, 0, 100);
            SEG_RED:    res = mk_rgba(255, 0, 0, 180);
            SEG_YELLOW: res = mk_rgba(255, 255, 100, 220);
            default:    res = mk_rgba(0, 0, 0, 0);
        endcase
        return res;
    endfunction

    function automatic t_rgba seg_end(input logic [SEG_W-1:0] seg);
        t_rgba res;
        case (seg)
            SEG_COLD:   res = mk_rgba(0, 121, 241, 100);
            SEG_ICE:    res = mk_rgba(255, 255, 255, 0);
            SEG_WHITE:  res = mk_rgba(200, 100, 0, 50);
            SEG_ORANGE: res = mk_rgba(255, 0, 0, 180);
            SEG_RED:    res = mk_rgba(255, 255, 100, 220);
            SEG_YELLOW: res = mk_rgba(255, 255, 255, 255);
            default:    res = mk_rgba(0, 0, 0, 0);
        endcase
        return res;
    endfunction

    function automatic logic [D_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
        logic [D_W-1:0] res;
        case (seg)
            SEG_COLD:   res = D_W'(SPAN_COLD);
            SEG_ICE:    res = D_W'(SPAN_ICE);
            SEG_WHITE:  res = D_W'(SPAN_WHITE);
            SEG_ORANGE: res = D_W'(SPAN_ORANGE);
            SEG_RED:    res = D_W'(SPAN_RED);
            SEG_YELLOW: res = D_W'(SPAN_YELLOW);
            default:    res = D_W'(SPAN_YELLOW);
        endcase
        return res;
    endfunction

    // floor(2^RCP_SHIFT / span), estimate is at most one low
    function automatic logic [RCP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
        logic [RCP_W-1:0] res;
        case (seg)
            SEG_COLD:   res = RCP_W'(RCP_COLD);
            SEG_ICE:    res = RCP_W'(RCP_ICE);
            SEG_WHITE:  res = RCP_W'(RCP_WHITE);
            SEG_ORANGE: res = RCP_W'(RCP_ORANGE);
            SEG_RED:    res = RCP_W'(RCP_RED);
            SEG_YELLOW: res = RCP_W'(RCP_YELLOW);
            default:    res = RCP_W'(RCP_YELLOW);
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/thmc_if.sv */
// valid/ready channel interfaces for temperature beats and color beats
`default_nettype none
interface thmc_in_if;
    import thmc_pkg::*;
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] temperature;
    logic [GLOW_W-1:0] glow_intensity;

    modport source (output valid, output temperature, output glow_intensity, input ready);
    modport sink   (input valid, input temperature, input glow_intensity, output ready);
endinterface

interface thmc_out_if;
    import thmc_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface
`default_nettype wire

/* design/temperature_heat_colormap_core.sv */
// heat colormap top level: temperature and glow in, rgba color out
// throughput: one beat per cycle while the output is not stalled; six elastic stages, each with its own valid bit,
// so bubbles are squeezed out and a stalled output holds without loss
// the critical path is the 19x20 reciprocal multiply of the blend divider
// reset clears only the stage valid bits; input ready is high from the first reset edge on
`default_nettype none
module temperature_heat_colormap_core
    import thmc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    thmc_in_if.sink   i_pix,
    thmc_out_if.source o_pix
);
    logic              w_seg_valid, w_seg_ready;
    logic [SEG_W-1:0]  w_seg;
    logic [D_W-1:0]    w_d;
    logic [GLOW_W-1:0] w_seg_glow;
    logic              w_lerp_valid, w_lerp_ready;
    t_rgba             w_lerp_rgba;
    logic [GLOW_W-1:0] w_lerp_glow;
    t_rgba             w_out_rgba;

    thmc_seg u_seg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_pix.valid),
        .o_ready       (i_pix.ready),
        .i_temperature (i_pix.temperature),
        .i_glow        (i_pix.glow_intensity),
        .o_valid       (w_seg_valid),
        .i_ready       (w_seg_ready),
        .o_seg         (w_seg),
        .o_d           (w_d),
        .o_glow        (w_seg_glow)
    );

    thmc_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_valid),
        .o_ready (w_seg_ready),
        .i_seg   (w_seg),
        .i_d     (w_d),
        .i_glow  (w_seg_glow),
        .o_valid (w_lerp_valid),
        .i_ready (w_lerp_ready),
        .o_rgba  (w_lerp_rgba),
        .o_glow  (w_lerp_glow)
    );

    thmc_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lerp_valid),
        .o_ready (w_lerp_ready),
        .i_rgba  (w_lerp_rgba),
        .i_glow  (w_lerp_glow),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_rgba  (w_out_rgba)
    );

    assign o_pix.red   = w_out_rgba[CH_R];
    assign o_pix.green = w_out_rgba[CH_G];
    assign o_pix.blue  = w_out_rgba[CH_B];
    assign o_pix.alpha = w_out_rgba[CH_A];
endmodule
`default_nettype wire

/* design/thmc_seg.sv */
// segment decode and in-segment offset, one register stage
`default_nettype none
module thmc_seg
    import thmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [TEMP_W-1:0] i_temperature,
    input  wire logic [GLOW_W-1:0] i_glow,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [SEG_W-1:0]       o_seg,
    output logic [D_W-1:0]         o_d,
    output logic [GLOW_W-1:0]      o_glow
);
    logic              r_valid;
    logic [SEG_W-1:0]  r_seg,  n_seg;
    logic [D_W-1:0]    r_d,    n_d;
    logic [GLOW_W-1:0] r_glow;
    logic [TEMP_W-1:0] w_off;
    logic              w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        if (i_temperature < T_ICE) begin
            n_seg = SEG_COLD;
            w_off = i_temperature;
        end else if (i_temperature < T_WHITE) begin
            n_seg = SEG_ICE;
            w_off = i_temperature - T_ICE;
        end else if (i_temperature < T_ORANGE) begin
            n_seg = SEG_WHITE;
            w_off = i_temperature - T_WHITE;
        end else if (i_temperature < T_RED) begin
            n_seg = SEG_ORANGE;
            w_off = i_temperature - T_ORANGE;
        end else if (i_temperature < T_YELLOW) begin
            n_seg = SEG_RED;
            w_off = i_temperature - T_RED;
        end else begin
            n_seg = SEG_YELLOW;
            // offset saturates at the full span
            if (i_temperature >= T_SAT) begin
                w_off = T_SAT - T_YELLOW;
            end else begin
                w_off = i_temperature - T_YELLOW;
            end
        end
        n_d = w_off[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_seg  <= n_seg;
            r_d    <= n_d;
            r_glow <= i_glow;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;
    assign o_d     = r_d;
    assign o_glow  = r_glow;
endmodule
`default_nettype wire

/* design/thmc_lerp.sv */
// per-channel blend: numerator, reciprocal estimate, correction (three stages)
`default_nettype none
module thmc_lerp
    import thmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [SEG_W-1:0]  i_seg,
    input  wire logic [D_W-1:0]    i_d,
    input  wire logic [GLOW_W-1:0] i_glow,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_rgba                  o_rgba,
    output logic [GLOW_W-1:0]      o_glow
);
    // stage a: numerator c1*(span-d) + c2*d
    logic              r_a_valid;
    logic [SEG_W-1:0]  r_a_seg;
    logic [GLOW_W-1:0] r_a_glow;
    t_num              r_a_num, n_a_num;
    // stage b: quotient estimate by reciprocal
    logic              r_b_valid;
    logic [SEG_W-1:0]  r_b_seg;
    logic [GLOW_W-1:0] r_b_glow;
    t_num              r_b_num;
    t_rgba             r_b_q, n_b_q;
    // stage c: corrected quotient
    logic              r_c_valid;
    logic [GLOW_W-1:0] r_c_glow;
    t_rgba             r_c_q, n_c_q;

    logic w_en_a, w_en_b, w_en_c;

    assign w_en_c  = !r_c_valid || i_ready;
    assign w_en_b  = !r_b_valid || w_en_c;
    assign w_en_a  = !r_a_valid || w_en_b;
    assign o_ready = w_en_a;

    always_comb begin
        t_rgba          c1;
        t_rgba          c2;
        logic [D_W-1:0] span;
        c1   = seg_start(i_seg);
        c2   = seg_end(i_seg);
        span = seg_span(i_seg);
        for (int c = 0; c < N_CH; c++) begin
            n_a_num[c] = NUM_W'(c1[c]) * NUM_W'(span - i_d) + NUM_W'(c2[c]) * NUM_W'(i_d);
        end
    end

    always_comb begin
        logic [RCP_W-1:0]  rcp;
        logic [PROD_W-1:0] prod;
        rcp = seg_recip(r_a_seg);
        for (int c = 0; c < N_CH; c++) begin
            prod       = PROD_W'(r_a_num[c]) * PROD_W'(rcp);
            n_b_q[c]   = prod[RCP_SHIFT +: CH_W];
        end
    end

    always_comb begin
        logic [D_W-1:0]   span;
        logic [NUM_W-1:0] rem;
        span = seg_span(r_b_seg);
        for (int c = 0; c < N_CH; c++) begin
            rem = r_b_num[c] - NUM_W'(r_b_q[c]) * NUM_W'(span);
            if (rem >= NUM_W'(span)) begin
                n_c_q[c] = r_b_q[c] + CH_W'(1);
            end else begin
                n_c_q[c] = r_b_q[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_valid <= i_valid;
            end
            if (w_en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_en_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a && i_valid) begin
            r_a_seg  <= i_seg;
            r_a_glow <= i_glow;
            r_a_num  <= n_a_num;
        end
        if (w_en_b && r_a_valid) begin
            r_b_seg  <= r_a_seg;
            r_b_glow <= r_a_glow;
            r_b_num  <= r_a_num;
            r_b_q    <= n_b_q;
        end
        if (w_en_c && r_b_valid) begin
            r_c_glow <= r_b_glow;
            r_c_q    <= n_c_q;
        end
    end

    assign o_valid = r_c_valid;
    assign o_rgba  = r_c_q;
    assign o_glow  = r_c_glow;
endmodule
`default_nettype wire

/* design/thmc_alpha.sv */
// alpha glow scaling: product stage, then divide by 255 into the output register
`default_nettype none
module thmc_alpha
    import thmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_rgba             i_rgba,
    input  wire logic [GLOW_W-1:0] i_glow,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_rgba                  o_rgba
);
    logic                 r_p_valid;
    t_rgba                r_p_rgb;
    logic [ALPHA_P_W-1:0] r_p_prod;
    logic                 r_o_valid;
    t_rgba                r_o_rgba, n_o_rgba;
    logic                 w_en_p, w_en_o;

    assign w_en_o  = !r_o_valid || i_ready;
    assign w_en_p  = !r_p_valid || w_en_o;
    assign o_ready = w_en_p;

    // p/255 via p*257 >> 16, estimate at most one low
    always_comb begin
        logic [P_EXT_W-1:0]   ext;
        logic [CH_W-1:0]      q0;
        logic [ALPHA_P_W-1:0] rem;
        ext = P_EXT_W'(r_p_prod) + (P_EXT_W'(r_p_prod) << CH_W);
        q0  = ext[ALPHA_P_W +: CH_W];
        rem = r_p_prod - ((ALPHA_P_W'(q0) << CH_W) - ALPHA_P_W'(q0));
        n_o_rgba = r_p_rgb;
        if (rem >= ALPHA_P_W'(255)) begin
            n_o_rgba[CH_A] = q0 + CH_W'(1);
        end else begin
            n_o_rgba[CH_A] = q0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_en_p) begin
                r_p_valid <= i_valid;
            end
            if (w_en_o) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_p && i_valid) begin
            r_p_rgb  <= i_rgba;
            r_p_prod <= ALPHA_P_W'(i_rgba[CH_A]) * ALPHA_P_W'(i_glow);
        end
        if (w_en_o && r_p_valid) begin
            r_o_rgba <= n_o_rgba;
        end
    end

    assign o_valid = r_o_valid;
    assign o_rgba  = r_o_rgba;
endmodule
`default_nettype wire
